// ===== rtl/allpass_comb_reverb_macros.svh =====
// assertion macros for the reverb block
`ifndef ALLPASS_COMB_REVERB_MACROS_SVH
`define ALLPASS_COMB_REVERB_MACROS_SVH
`ifndef SYNTHESIS
`define ACR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ACR_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m failed");
`else
`define ACR_ASSERT(label, clk, rst_n, prop)
`define ACR_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/acr_pkg.sv =====
// shared types, constants and helper functions of the reverb block
package acr_pkg;
  localparam int unsigned WordW = 24;
  localparam int unsigned CoefW = 16;
  localparam logic signed [WordW-1:0] WordMax = 24'sh7fffff;
  localparam logic signed [WordW-1:0] WordMin = -24'sh800000;

  localparam logic [3:0] RegRoom = 4'd0;
  localparam logic [3:0] RegApFb = 4'd1;
  localparam logic [3:0] RegApFw = 4'd2;
  localparam logic [3:0] RegCg2  = 4'd3;
  localparam logic [3:0] RegCg3  = 4'd4;
  localparam logic [3:0] RegCg5  = 4'd5;
  localparam logic [3:0] RegCg7  = 4'd6;

  // queued transaction between front and back
  typedef struct packed {
    logic signed [15:0] sample;
    logic               clear;
  } item_t;

  function automatic logic [2:0] stage_prime(input logic [1:0] i);
    unique case (i)
      2'd0: stage_prime = 3'd2;
      2'd1: stage_prime = 3'd3;
      2'd2: stage_prime = 3'd5;
      default: stage_prime = 3'd7;
    endcase
  endfunction

  function automatic logic signed [WordW-1:0] sat_word(input logic signed [47:0] v);
    if (v > 48'sd8388607) sat_word = WordMax;
    else if (v < -48'sd8388608) sat_word = WordMin;
    else sat_word = v[WordW-1:0];
  endfunction
endpackage

// ===== rtl/acr_front.sv =====
// input stage and two-entry queue of accepted transactions
module acr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [15:0]  sample_in_i,
  input  logic                clear_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output acr_pkg::item_t      q_item_o
);
  import acr_pkg::*;
  item_t       mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{sample: sample_in_i, clear: clear_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule

// ===== rtl/acr_back.sv =====
// sequencer over the delay lines with one shared multiplier
module acr_back #(
  parameter int unsigned DelayDepth = 4096,
  parameter int unsigned ApStages   = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  acr_pkg::item_t      q_item_i,
  input  logic [9:0]          room_i,
  input  logic signed [15:0]  ap_fb_i,
  input  logic signed [15:0]  ap_fw_i,
  input  logic [14:0]         cg2_i,
  input  logic [14:0]         cg3_i,
  input  logic [14:0]         cg5_i,
  input  logic [14:0]         cg7_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  sample_out_o
);
  import acr_pkg::*;
  localparam int unsigned AW = $clog2(DelayDepth);
  localparam int unsigned MemAW = AW + 3;
  localparam int unsigned RoomLim = DelayDepth / 7;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_MUL1, S_MUL2, S_OUT
  } state_e;

  state_e                   state_q;
  logic [2:0]               slot_q;
  logic signed [WordW-1:0]  x_q, d_q, t_q;
  logic signed [WordW+1:0]  sum_q;
  logic                     rd_pend_q;
  logic [AW-1:0]            pos_q [8];
  // entries at or above the fill count of a line have not been written since clear
  logic [AW:0]              fill_q [8];
  logic                     hit_q;
  logic signed [WordW-1:0]  mem [8 << AW];
  logic signed [WordW-1:0]  rdata_q;
  logic signed [15:0]       out_q;
  logic                     out_v_q;

  // effective room and line length
  logic [9:0]   room_eff;
  logic [AW-1:0] pos_cur, pos_nxt;
  logic [16:0]  len_w;
  always_comb begin
    room_eff = room_i;
    if (room_eff == 10'd0) room_eff = 10'd1;
    if ({6'd0, room_eff} > 16'(RoomLim)) room_eff = 10'(RoomLim);
    len_w = 17'(room_eff) * 17'(stage_prime(slot_q[1:0]));
    pos_cur = ({{(17-AW){1'b0}}, pos_q[slot_q]} >= len_w) ? '0 : pos_q[slot_q];
    pos_nxt = ({{(17-AW){1'b0}}, pos_cur} + 17'd1 >= len_w) ? '0 : pos_cur + 1'b1;
  end

  logic [MemAW-1:0] addr;
  assign addr = {slot_q, pos_cur};

  // shared multiplier: word times coefficient, round half up
  logic signed [WordW-1:0] m_word;
  logic signed [16:0]      m_coef;
  logic signed [41:0]      prod;
  logic signed [47:0]      qm;
  always_comb begin
    m_word = (state_q == S_MUL1) ? d_q : t_q;
    unique case (slot_q)
      3'd4: m_coef = {2'b00, cg2_i};
      3'd5: m_coef = {2'b00, cg3_i};
      3'd6: m_coef = {2'b00, cg5_i};
      3'd7: m_coef = {2'b00, cg7_i};
      default: m_coef = (state_q == S_MUL1) ? 17'(ap_fb_i) : 17'(ap_fw_i);
    endcase
    prod = 42'(m_word) * 42'(m_coef);
    qm = 48'((prod + 42'sd16384) >>> 15);
  end

  logic signed [WordW-1:0] t_new;
  assign t_new = sat_word(48'(x_q) + qm);

  logic mem_we;
  assign mem_we = (state_q == S_MUL1);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[addr] <= t_new;
    rdata_q <= mem[addr];
  end

  logic [2:0] last_ap;
  assign last_ap = 3'(ApStages - 1);
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;
  assign out_valid_o = out_v_q;
  assign sample_out_o = out_q;

  logic signed [WordW+1:0] msum;
  logic signed [WordW-1:0] mean;
  always_comb begin
    msum = (sum_q + 26'sd2) >>> 2;
    mean = msum[WordW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q <= '0;
      out_v_q <= 1'b0;
      rd_pend_q <= 1'b0;
      hit_q <= 1'b0;
      for (int i = 0; i < 8; i++) pos_q[i] <= '0;
      for (int i = 0; i < 8; i++) fill_q[i] <= '0;
      x_q <= '0; d_q <= '0; t_q <= '0; sum_q <= '0; out_q <= '0;
    end else begin
      hit_q <= ({1'b0, pos_cur} < fill_q[slot_q]);
      if (state_q != S_OUT && out_v_q && !out_stall_i) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (q_pop_o) begin
            x_q <= WordW'(q_item_i.sample);
            sum_q <= '0;
            slot_q <= '0;
            if (q_item_i.clear) begin
              for (int i = 0; i < 8; i++) pos_q[i] <= '0;
              for (int i = 0; i < 8; i++) fill_q[i] <= '0;
            end
            state_q <= S_READ;
          end
        end
        S_READ: begin
          rd_pend_q <= ~rd_pend_q;
          if (rd_pend_q) begin
            d_q <= hit_q ? rdata_q : '0;
            state_q <= S_MUL1;
          end
        end
        S_MUL1: begin
          t_q <= t_new;
          pos_q[slot_q] <= pos_nxt;
          if ({1'b0, pos_cur} == fill_q[slot_q]) fill_q[slot_q] <= fill_q[slot_q] + 1'b1;
          if (slot_q[2]) begin
            sum_q <= sum_q + 26'(t_new);
            if (slot_q == 3'd7) state_q <= S_OUT;
            else begin slot_q <= slot_q + 3'd1; state_q <= S_READ; end
          end else state_q <= S_MUL2;
        end
        S_MUL2: begin
          x_q <= sat_word(48'(d_q) - qm);
          slot_q <= (slot_q == last_ap) ? 3'd4 : slot_q + 3'd1;
          state_q <= S_READ;
        end
        S_OUT: begin
          // wait here while the previous result is still stalled
          if (!out_v_q || !out_stall_i) begin
            if (msum > 26'sd32767) out_q <= 16'sh7fff;
            else if (msum < -26'sd32768) out_q <= -16'sh8000;
            else out_q <= mean[15:0];
            out_v_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/allpass_comb_reverb.sv =====
// top level of the reverb: config registers, front queue and back sequencer
// sequence: the back pops a transaction only while idle, then for each line reads the delay
// line and multiplies, with a further multiply on each allpass line, then moves to output;
// output waits while the previous result is stalled, and no new transaction starts before it
// clear: taken when the transaction is popped, fill counts mark every line as unwritten
// reset: registers take their defaults, positions and fill counts zero, lines read zero
module allpass_comb_reverb #(
  parameter int unsigned DELAY_DEPTH    = 4096,
  parameter int unsigned ALLPASS_STAGES = 4,
  parameter int unsigned COMB_STAGES    = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] sample_in_i,
  input  logic               clear_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sample_out_o
);
  import acr_pkg::*;
  `include "allpass_comb_reverb_macros.svh"

  logic [9:0]         room_q;
  logic signed [15:0] apfb_q, apfw_q;
  logic [14:0]        cg2_q, cg3_q, cg5_q, cg7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_q <= 10'd585;
      apfb_q <= 16'sd22938;
      apfw_q <= 16'sd22938;
      cg2_q <= 15'd4555;
      cg3_q <= 15'd1697;
      cg5_q <= 15'd236;
      cg7_q <= 15'd33;
    end else if (cfg_we_i && COMB_STAGES == 4) begin
      unique case (cfg_index_i)
        RegRoom: room_q <= cfg_data_i[9:0];
        RegApFb: apfb_q <= cfg_data_i;
        RegApFw: apfw_q <= cfg_data_i;
        RegCg2:  cg2_q <= cfg_data_i[14:0];
        RegCg3:  cg3_q <= cfg_data_i[14:0];
        RegCg5:  cg5_q <= cfg_data_i[14:0];
        RegCg7:  cg7_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  logic  q_valid, q_pop;
  item_t q_item;

  acr_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sample_in_i, .clear_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  acr_back #(.DelayDepth(DELAY_DEPTH), .ApStages(ALLPASS_STAGES)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .room_i(room_q), .ap_fb_i(apfb_q), .ap_fw_i(apfw_q),
    .cg2_i(cg2_q), .cg3_i(cg3_q), .cg5_i(cg5_q), .cg7_i(cg7_q),
    .out_valid_o, .out_stall_i, .sample_out_o
  );

  `ACR_ASSERT(a_pop_needs_item, clk_i, rst_ni, q_pop |-> q_valid)
  `ACR_ASSERT(a_out_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(sample_out_o))
  `ACR_ASSERT(a_out_valid_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)
endmodule
